@@ src/crf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types, widths and constants of the clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package crf_pkg;

    // Field widths.
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned DIM_W    = 12;
    localparam int unsigned STRIDE_W = 13;
    localparam int unsigned PIX_W    = 11;
    localparam int unsigned INDEX_W  = 23;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 13;

    // Largest screen the engine addresses.
    localparam logic [DIM_W-1:0] MAX_WIDTH  = 12'd2048;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 12'd2048;

    // Values after reset.
    localparam logic [DIM_W-1:0]    RST_DISP_WIDTH  = 12'd1920;
    localparam logic [DIM_W-1:0]    RST_DISP_HEIGHT = 12'd1200;
    localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE  = 13'd1920;

    // Command codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_XEND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_YEND   = 3'd6;

    // Configuration register file contents.
    typedef struct packed {
        logic [DIM_W-1:0]    disp_width;
        logic [DIM_W-1:0]    disp_height;
        logic [STRIDE_W-1:0] row_stride;
        logic [DIM_W-1:0]    clip_left;
        logic [DIM_W-1:0]    clip_top;
        logic [DIM_W-1:0]    clip_xend;
        logic [DIM_W-1:0]    clip_yend;
    } crf_cfg_t;

    // One command transaction.
    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [COLOR_W-1:0] fill_color;
    } crf_cmd_t;

    // Clipped rectangle handed from the clip unit to the walker.
    typedef struct packed {
        logic               ok;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   top;
        logic [DIM_W-1:0]   right;
        logic [DIM_W-1:0]   bottom;
        logic [INDEX_W-1:0] row_base;
    } crf_span_t;

    // One pixel write.
    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_value;
        logic               last_pixel;
    } crf_pixel_t;

    // Walker status seen by the top level.
    typedef struct packed {
        logic busy;
        logic emit;
        logic last;
    } crf_walk_status_t;

endpackage

@@ src/crf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_cmd_if / crf_pixel_if
// Valid/ready channels for fill commands and pixel writes.
// ----------------------------------------------------------------------------
interface crf_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [crf_pkg::COORD_W-1:0] rect_x;
    logic [crf_pkg::COORD_W-1:0] rect_y;
    logic [crf_pkg::COORD_W-1:0] rect_width;
    logic [crf_pkg::COORD_W-1:0] rect_height;
    logic [crf_pkg::COLOR_W-1:0] fill_color;

    modport source (
        output valid, opcode, rect_x, rect_y, rect_width, rect_height, fill_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, rect_x, rect_y, rect_width, rect_height, fill_color,
        output ready
    );
endinterface

interface crf_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [crf_pkg::INDEX_W-1:0] pixel_index;
    logic [crf_pkg::PIX_W-1:0]   pixel_x;
    logic [crf_pkg::PIX_W-1:0]   pixel_y;
    logic [crf_pkg::COLOR_W-1:0] pixel_value;
    logic                        last_pixel;

    modport source (
        output valid, pixel_index, pixel_x, pixel_y, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, pixel_x, pixel_y, pixel_value, last_pixel,
        output ready
    );
endinterface

@@ src/crf_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_cfg
// Configuration register file: screen size, row stride and clip window.
// ----------------------------------------------------------------------------
module crf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output crf_pkg::crf_cfg_t              cfg
);

    crf_pkg::crf_cfg_t cfg_reg;
    crf_pkg::crf_cfg_t cfg_next;

    // Decode the write; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                crf_pkg::CFG_DISP_WIDTH:
                    cfg_next.disp_width = cfg_wdata[crf_pkg::DIM_W-1:0];
                crf_pkg::CFG_DISP_HEIGHT:
                    cfg_next.disp_height = cfg_wdata[crf_pkg::DIM_W-1:0];
                crf_pkg::CFG_ROW_STRIDE:
                    cfg_next.row_stride = cfg_wdata;
                crf_pkg::CFG_CLIP_LEFT:
                    cfg_next.clip_left = cfg_wdata[crf_pkg::DIM_W-1:0];
                crf_pkg::CFG_CLIP_TOP:
                    cfg_next.clip_top = cfg_wdata[crf_pkg::DIM_W-1:0];
                crf_pkg::CFG_CLIP_XEND:
                    cfg_next.clip_xend = cfg_wdata[crf_pkg::DIM_W-1:0];
                crf_pkg::CFG_CLIP_YEND:
                    cfg_next.clip_yend = cfg_wdata[crf_pkg::DIM_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers with their reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disp_width  <= crf_pkg::RST_DISP_WIDTH;
            cfg_reg.disp_height <= crf_pkg::RST_DISP_HEIGHT;
            cfg_reg.row_stride  <= crf_pkg::RST_ROW_STRIDE;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_xend   <= crf_pkg::RST_DISP_WIDTH;
            cfg_reg.clip_yend   <= crf_pkg::RST_DISP_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/crf_clip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_clip
// Clips a requested rectangle against the screen and the clip window and
// computes the buffer index of its first row.
// ----------------------------------------------------------------------------
module crf_clip (
    input  crf_pkg::crf_cmd_t  cmd,
    input  crf_pkg::crf_cfg_t  cfg,
    output crf_pkg::crf_span_t span
);

    logic [crf_pkg::DIM_W-1:0]     sw;
    logic [crf_pkg::DIM_W-1:0]     sh;
    logic [crf_pkg::COORD_W:0]     x_end;
    logic [crf_pkg::COORD_W:0]     y_end;
    logic [crf_pkg::DIM_W-1:0]     right_scr;
    logic [crf_pkg::DIM_W-1:0]     bottom_scr;
    logic [crf_pkg::DIM_W-1:0]     right_clip;
    logic [crf_pkg::DIM_W-1:0]     bottom_clip;
    logic [crf_pkg::COORD_W-1:0]   left_full;
    logic [crf_pkg::COORD_W-1:0]   top_full;
    logic                          visible;
    logic [crf_pkg::PIX_W+crf_pkg::STRIDE_W-1:0] base_prod;

    // Screen size saturated to the largest supported screen.
    assign sw = (cfg.disp_width  > crf_pkg::MAX_WIDTH)  ? crf_pkg::MAX_WIDTH
                                                         : cfg.disp_width;
    assign sh = (cfg.disp_height > crf_pkg::MAX_HEIGHT) ? crf_pkg::MAX_HEIGHT
                                                         : cfg.disp_height;

    // Far edges, clipped first to the screen and then to the window.
    assign x_end = {1'b0, cmd.rect_x} + {1'b0, cmd.rect_width};
    assign y_end = {1'b0, cmd.rect_y} + {1'b0, cmd.rect_height};
    assign right_scr  = (x_end < {5'b0, sw}) ? x_end[crf_pkg::DIM_W-1:0] : sw;
    assign bottom_scr = (y_end < {5'b0, sh}) ? y_end[crf_pkg::DIM_W-1:0] : sh;
    assign right_clip  = (cfg.clip_xend < right_scr)  ? cfg.clip_xend : right_scr;
    assign bottom_clip = (cfg.clip_yend < bottom_scr) ? cfg.clip_yend : bottom_scr;

    // Near edges pushed in by the window.
    assign left_full = (cmd.rect_x > {4'b0, cfg.clip_left}) ? cmd.rect_x
                                                             : {4'b0, cfg.clip_left};
    assign top_full  = (cmd.rect_y > {4'b0, cfg.clip_top})  ? cmd.rect_y
                                                             : {4'b0, cfg.clip_top};

    // Empty, off-screen or fully clipped rectangles are dropped.
    assign visible = (cmd.rect_width != '0) && (cmd.rect_height != '0)
                  && (cmd.rect_x < {4'b0, sw}) && (cmd.rect_y < {4'b0, sh})
                  && ({4'b0, right_clip} > left_full)
                  && ({4'b0, bottom_clip} > top_full);

    // Buffer index of the first row, modulo the index width.
    assign base_prod = top_full[crf_pkg::PIX_W-1:0] * cfg.row_stride;

    assign span.ok       = visible;
    assign span.left     = left_full[crf_pkg::PIX_W-1:0];
    assign span.top      = top_full[crf_pkg::PIX_W-1:0];
    assign span.right    = right_clip;
    assign span.bottom   = bottom_clip;
    assign span.row_base = base_prod[crf_pkg::INDEX_W-1:0];

endmodule

@@ src/crf_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_walker
// Holds the armed rectangle and walks it in raster order, one pixel for
// each accepted step transaction.
// ----------------------------------------------------------------------------
module crf_walker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              opcode,
    input  logic [crf_pkg::COLOR_W-1:0]       fill_color,
    input  logic [crf_pkg::STRIDE_W-1:0]      row_stride,
    input  crf_pkg::crf_span_t                span,
    output crf_pkg::crf_pixel_t               pixel,
    output crf_pkg::crf_walk_status_t         status
);

    logic                        busy_reg,     busy_next;
    logic [crf_pkg::PIX_W-1:0]   cur_col_reg,  cur_col_next;
    logic [crf_pkg::PIX_W-1:0]   cur_row_reg,  cur_row_next;
    logic [crf_pkg::PIX_W-1:0]   span_left_reg, span_left_next;
    logic [crf_pkg::DIM_W-1:0]   end_col_reg,  end_col_next;
    logic [crf_pkg::DIM_W-1:0]   end_row_reg,  end_row_next;
    logic [crf_pkg::INDEX_W-1:0] row_base_reg, row_base_next;
    logic [crf_pkg::COLOR_W-1:0] color_reg,    color_next;
    logic                        emit;
    logic                        row_done;
    logic                        last;

    // End of row and end of rectangle for the current pixel.
    assign row_done = ({1'b0, cur_col_reg} + 12'd1) >= end_col_reg;
    assign last     = row_done && (({1'b0, cur_row_reg} + 12'd1) >= end_row_reg);
    assign emit     = accept && (opcode == crf_pkg::OP_STEP) && busy_reg;

    // Pixel at the current position.
    assign pixel.pixel_index = row_base_reg + {12'b0, cur_col_reg};
    assign pixel.pixel_x     = cur_col_reg;
    assign pixel.pixel_y     = cur_row_reg;
    assign pixel.pixel_value = color_reg;
    assign pixel.last_pixel  = last;

    // A start arms or cancels; a step advances the position.
    always_comb
    begin
        busy_next      = busy_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        span_left_next = span_left_reg;
        end_col_next   = end_col_reg;
        end_row_next   = end_row_reg;
        row_base_next  = row_base_reg;
        color_next     = color_reg;
        if (accept && (opcode == crf_pkg::OP_START))
        begin
            busy_next = span.ok;
            if (span.ok)
            begin
                cur_col_next   = span.left;
                cur_row_next   = span.top;
                span_left_next = span.left;
                end_col_next   = span.right;
                end_row_next   = span.bottom;
                row_base_next  = span.row_base;
                color_next     = fill_color;
            end
        end
        else if (emit)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else if (row_done)
            begin
                cur_col_next  = span_left_reg;
                cur_row_next  = cur_row_reg + 11'd1;
                row_base_next = row_base_reg + {10'b0, row_stride};
            end
            else
            begin
                cur_col_next = cur_col_reg + 11'd1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Rectangle and position; only meaningful while busy.
    always_ff @(posedge clk)
    begin
        cur_col_reg   <= cur_col_next;
        cur_row_reg   <= cur_row_next;
        span_left_reg <= span_left_next;
        end_col_reg   <= end_col_next;
        end_row_reg   <= end_row_next;
        row_base_reg  <= row_base_next;
        color_reg     <= color_next;
    end

    assign status.busy = busy_reg;
    assign status.emit = emit;
    assign status.last = last;

endmodule

@@ src/crf_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_out
// Output register for pixel writes; a new pixel may load in the same cycle
// the held one leaves.
// ----------------------------------------------------------------------------
module crf_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  crf_pkg::crf_pixel_t  pixel_in,
    output logic                 free,
    crf_pixel_if.source          pixel
);

    logic                valid_reg, valid_next;
    crf_pkg::crf_pixel_t data_reg,  data_next;

    // The slot is free when empty or when its transaction completes now.
    assign free = !valid_reg || pixel.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (free)
        begin
            valid_next = load;
            if (load)
            begin
                data_next = pixel_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign pixel.valid       = valid_reg;
    assign pixel.pixel_index = data_reg.pixel_index;
    assign pixel.pixel_x     = data_reg.pixel_x;
    assign pixel.pixel_y     = data_reg.pixel_y;
    assign pixel.pixel_value = data_reg.pixel_value;
    assign pixel.last_pixel  = data_reg.last_pixel;

endmodule

@@ src/clipped_rectangle_fill.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rectangle_fill
// Rectangle fill engine with screen and clip-window clipping.
// ----------------------------------------------------------------------------
// A start command (opcode 0) clips the requested rectangle against the screen
// and the clip window and arms the engine; an empty result cancels any fill in
// progress. Each step command (opcode 1) then yields one pixel write in raster
// order, with last_pixel set on the final one; a step while idle yields
// nothing. The engine takes one command per clock: a step's pixel appears in
// the output register on the next clock, and commands keep flowing as long as
// that register drains. The start path holds the clip compares and an 11 by 13
// bit multiply for the first row's buffer index. Configuration must be written
// only while no fill is pending; the engine itself does not enforce this.
module clipped_rectangle_fill (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    crf_cmd_if.sink                        cmd,
    crf_pixel_if.source                    pixel
);

    crf_pkg::crf_cfg_t         cfg;
    crf_pkg::crf_cmd_t         cmd_word;
    crf_pkg::crf_span_t        span;
    crf_pkg::crf_pixel_t       walk_pixel;
    crf_pkg::crf_walk_status_t status;
    logic                      slot_free;
    logic                      accept;

    // Commands are taken whenever the output slot can take a pixel.
    assign cmd.ready = slot_free;
    assign accept    = cmd.valid && slot_free;

    assign cmd_word.opcode      = cmd.opcode;
    assign cmd_word.rect_x      = cmd.rect_x;
    assign cmd_word.rect_y      = cmd.rect_y;
    assign cmd_word.rect_width  = cmd.rect_width;
    assign cmd_word.rect_height = cmd.rect_height;
    assign cmd_word.fill_color  = cmd.fill_color;

    // Configuration registers.
    crf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Clipping of start commands.
    crf_clip u_clip (
        .cmd  (cmd_word),
        .cfg  (cfg),
        .span (span)
    );

    // Raster walk.
    crf_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (cmd_word.opcode),
        .fill_color (cmd_word.fill_color),
        .row_stride (cfg.row_stride),
        .span       (span),
        .pixel      (walk_pixel),
        .status     (status)
    );

    // Output register.
    crf_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (status.emit),
        .pixel_in (walk_pixel),
        .free     (slot_free),
        .pixel    (pixel)
    );

`ifndef SYNTH
    // A start whose rectangle clips to nothing leaves the engine idle.
    a_empty_start_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.opcode == crf_pkg::OP_START) && !span.ok) |=> !status.busy)
        else $error("empty start did not leave the engine idle");

    // The final pixel of a rectangle ends the fill.
    a_last_ends_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (status.emit && status.last) |=> !status.busy)
        else $error("engine stayed busy after the last pixel");

    // A new pixel appears only after an accepted step transaction.
    a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel.valid) |-> $past(accept && (cmd.opcode == crf_pkg::OP_STEP)))
        else $error("pixel produced without a step transaction");
`endif

endmodule
